// ===== rtl/fps_pkg.sv =====
`timescale 1ns / 1ps
package fps_pkg;

  localparam int IDX_W   = 16;
  localparam int CNT_W   = 17;
  localparam int MODE_W  = 3;
  localparam int RULE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // last index of a path; the point there always closes the path
  localparam logic [IDX_W-1:0] IDX_MAX  = '1;
  localparam logic [IDX_W-1:0] END_NONE = '1;

  localparam logic [MODE_W-1:0] MODE_SPLIT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DISCONNECT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PARTITION  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWITCH     = 3'd4;

  localparam logic [RULE_W-1:0] RULE_CONST          = 2'd0;
  localparam logic [RULE_W-1:0] RULE_CONST_PRESERVE = 2'd1;
  localparam logic [RULE_W-1:0] RULE_FROM_POINT     = 2'd2;
  localparam logic [RULE_W-1:0] RULE_FROM_POINT_INV = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUSIVE_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RULE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] split_mode;
    logic              inclusive_end;
    logic [RULE_W-1:0] initial_rule;
    logic              initial_value;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic             seg_open;
    logic [IDX_W-1:0] open_start;
    logic [CNT_W-1:0] open_count;
    logic             toggle;
    logic             even_bit;
    logic             open_even;
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] seg_start;
    logic [IDX_W-1:0] seg_end;
    logic [CNT_W-1:0] seg_count;
    logic             runs_to_end;
    logic             seg_even;
    logic             last_result;
  } result_t;

  localparam state_t STATE_RESTART = '{
    point_index: '0,
    seg_open:    1'b0,
    open_start:  '0,
    open_count:  '0,
    toggle:      1'b0,
    even_bit:    1'b1,
    open_even:   1'b0
  };

endpackage

// ===== rtl/fps_step.sv =====
`timescale 1ns / 1ps
module fps_step (
  input  fps_pkg::cfg_t    cfg,
  input  fps_pkg::state_t  st,
  input  logic             point_flag,
  input  logic             last_point,
  output fps_pkg::state_t  st_nxt,
  output fps_pkg::result_t res0,
  output fps_pkg::result_t res1,
  output logic [1:0]       res_n
);
  import fps_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] prev;
  logic             lst;
  logic             tmode;
  state_t           s;
  logic             a_vld;
  result_t          a;
  logic             b_vld;
  result_t          b;
  result_t          close_incl;
  result_t          close_excl;

  assign idx   = st.point_index;
  assign prev  = st.point_index - IDX_W'(1);
  assign lst   = last_point | (st.point_index == IDX_MAX);
  assign tmode = (cfg.split_mode == MODE_PARTITION) || (cfg.split_mode == MODE_SWITCH);

  always_comb begin
    s     = st;
    a_vld = 1'b0;
    a     = '0;
    b_vld = 1'b0;
    b     = '0;
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;

    // initial toggle rule, applied before the first point is handled
    if (tmode && (idx == '0)) begin
      unique case (cfg.initial_rule)
        RULE_CONST: s.toggle = cfg.initial_value;
        RULE_CONST_PRESERVE: begin
          if (cfg.initial_value == point_flag) s.toggle = ~s.toggle;
        end
        RULE_FROM_POINT: s.toggle = point_flag;
        default: s.toggle = ~point_flag;
      endcase
    end

    // closing forms of the open segment, inclusive or exclusive of this point
    close_incl             = '0;
    close_incl.seg_start   = st.open_start;
    close_incl.seg_end     = idx;
    close_incl.seg_count   = st.open_count + CNT_W'(1);
    close_excl             = '0;
    close_excl.seg_start   = st.open_start;
    close_excl.seg_end     = prev;
    close_excl.seg_count   = st.open_count;

    unique case (cfg.split_mode)
      MODE_SPLIT, MODE_REMOVE, MODE_DISCONNECT: begin
        if (!point_flag) begin
          if (!s.seg_open) begin
            s.seg_open   = 1'b1;
            s.open_start = idx;
            s.open_count = '0;
            s.open_even  = 1'b0;
          end
          s.open_count = s.open_count + CNT_W'(1);
        end else begin
          if (s.seg_open) begin
            a_vld      = 1'b1;
            a          = (cfg.split_mode == MODE_REMOVE) ? close_excl : close_incl;
            s.seg_open = 1'b0;
          end
          if (cfg.split_mode == MODE_SPLIT) begin
            // flagged point is shared: it also opens the next segment
            s.seg_open   = 1'b1;
            s.open_start = idx;
            s.open_count = CNT_W'(1);
            s.open_even  = 1'b0;
          end
        end
      end
      MODE_PARTITION: begin
        if (point_flag != s.toggle) begin
          s.toggle = ~s.toggle;
          if (s.seg_open) begin
            a_vld      = 1'b1;
            a          = cfg.inclusive_end ? close_incl : close_excl;
            a.seg_even = st.open_even;
            s.seg_open = 1'b0;
          end
        end
        if (!s.seg_open) begin
          s.seg_open   = 1'b1;
          s.open_start = idx;
          s.open_count = '0;
          s.open_even  = s.even_bit;
          s.even_bit   = ~s.even_bit;
        end
        s.open_count = s.open_count + CNT_W'(1);
      end
      MODE_SWITCH: begin
        if (point_flag) s.toggle = ~s.toggle;
        if (s.toggle) begin
          if (!s.seg_open) begin
            s.seg_open   = 1'b1;
            s.open_start = idx;
            s.open_count = '0;
            s.open_even  = 1'b0;
          end
          s.open_count = s.open_count + CNT_W'(1);
        end else if (s.seg_open) begin
          a_vld      = 1'b1;
          a          = cfg.inclusive_end ? close_incl : close_excl;
          s.seg_open = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // path end: flush whatever is still open
    if (lst && s.seg_open) begin
      b_vld         = 1'b1;
      b.seg_start   = s.open_start;
      b.seg_end     = END_NONE;
      b.seg_count   = s.open_count;
      b.runs_to_end = 1'b1;
      b.seg_even    = s.open_even;
    end

    if (a_vld) begin
      res0 = a;
      if (b_vld) begin
        res1             = b;
        res1.last_result = 1'b1;
        res_n            = 2'd2;
      end else begin
        res0.last_result = 1'b1;
        res_n            = 2'd1;
      end
    end else if (b_vld) begin
      res0             = b;
      res0.last_result = 1'b1;
      res_n            = 2'd1;
    end

    if (lst) begin
      s = STATE_RESTART;
    end else begin
      s.point_index = idx + IDX_W'(1);
    end
    st_nxt = s;
  end

endmodule

// ===== rtl/fps_out_fifo.sv =====
`timescale 1ns / 1ps
module fps_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                push_n,
  input  fps_pkg::result_t          push0,
  input  fps_pkg::result_t          push1,
  output logic                      full2,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fps_pkg::result_t          out_data,
  output logic [$clog2(fps_pkg::FIFO_DEPTH+1)-1:0] level
);
  import fps_pkg::*;

  result_t           mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r;
  logic [FCNT_W-1:0] count_nxt;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_p1;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign level     = count_r;
  // room for the two results one point can give
  assign full2     = (count_r > FCNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + FCNT_W'(push_n) - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_n == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

endmodule

// ===== rtl/flagged_path_segmenter.sv =====
`timescale 1ns / 1ps
// flagged_path_segmenter
// input channel: one point per transfer (in_point_flag, in_last_point), in path
// order; the point with in_last_point set closes the path, and a path that
// reaches index 65535 is closed there regardless
// result channel: one segment per transfer; out_last_result marks the final
// segment produced by a point, which gives zero, one or two segments
// config: cfg_we writes cfg_data into register cfg_index (0 split_mode,
// 1 inclusive_end, 2 initial_rule, 3 initial_value); write only while idle
// output: the segments of a point are written into the output buffer when
// the point transfers; throughput: one point per cycle while in_stall is low;
// the state updates on the transfer; results queue in a four-entry buffer
// in_stall rises while the buffer holds more than two segments, so a stalled
// receiver backs up into the input once three segments are waiting
// reset: clears the buffer, the configuration and the path state; the first
// point after reset is index 0 of a new path
module flagged_path_segmenter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_point_flag,
  input  logic                           in_last_point,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_seg_start,
  output logic [15:0]                    out_seg_end,
  output logic [16:0]                    out_seg_count,
  output logic                           out_runs_to_end,
  output logic                           out_seg_even,
  output logic                           out_last_result
);
  import fps_pkg::*;

  cfg_t              cfg_r;
  state_t            state_r;
  state_t            state_nxt;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_n;
  logic [1:0]        push_n;
  logic              in_xfer;
  result_t           head;
  logic [FCNT_W-1:0] level;

  assign in_xfer = in_valid & ~in_stall;
  assign push_n  = in_xfer ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPLIT_MODE:    cfg_r.split_mode    <= cfg_data[MODE_W-1:0];
        REG_INCLUSIVE_END: cfg_r.inclusive_end <= cfg_data[0];
        REG_INITIAL_RULE:  cfg_r.initial_rule  <= cfg_data[RULE_W-1:0];
        default:           cfg_r.initial_value <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESTART;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  fps_step u_step (
    .cfg        (cfg_r),
    .st         (state_r),
    .point_flag (in_point_flag),
    .last_point (in_last_point),
    .st_nxt     (state_nxt),
    .res0       (res0),
    .res1       (res1),
    .res_n      (res_n)
  );

  fps_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .full2     (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head),
    .level     (level)
  );

  assign out_seg_start   = head.seg_start;
  assign out_seg_end     = head.seg_end;
  assign out_seg_count   = head.seg_count;
  assign out_runs_to_end = head.runs_to_end;
  assign out_seg_even    = head.seg_even;
  assign out_last_result = head.last_result;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= FCNT_W'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_path_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_point) |=> (state_r.point_index == '0) && !state_r.seg_open)
    else $error("path state not restarted after last point");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_runs_to_end) |-> (out_seg_end == END_NONE) && out_last_result)
    else $error("open-at-end segment badly formed");

endmodule
